/* rtl/smsu_pkg.sv */
package smsu_pkg;

	localparam int NUM_MARKERS = 8;
	localparam int MAX_LEN     = 9;
	localparam int HIST_DEPTH  = 8;
	localparam int LEN_W       = 26;
	localparam int CODE_W      = 4;
	localparam int CHUNK_BYTES = 65536;
	localparam int CHUNK_W     = $clog2(CHUNK_BYTES + 1);
	localparam int ADDR_W      = 3;
	localparam int DATA_W      = 32;

	localparam logic [LEN_W-1:0] SCAN_LENGTH_RESET = LEN_W'(65536);
	localparam logic             REG_SCAN_LENGTH   = 1'b0;

	localparam logic [CODE_W-1:0] MARKER_NONE = 4'd0;
	localparam logic [CODE_W-1:0] MARKER_LAST = 4'd8;

	typedef logic [NUM_MARKERS-1:0]      mask_t;
	typedef logic [NUM_MARKERS-1:0][7:0] byte_row_t;

	localparam logic [7:0] MARKER_TEXT [NUM_MARKERS][MAX_LEN] = '{
		'{"S", "R", "A", "M", "_", "V", "1", "1", "1"},
		'{"S", "R", "A", "M", "_", "V", "1", "1", "2"},
		'{"S", "R", "A", "M", "_", "V", 8'h00, 8'h00, 8'h00},
		'{"S", "R", "A", "M", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"F", "L", "A", "S", "H", "1", "M", 8'h00, 8'h00},
		'{"F", "L", "A", "S", "H", "5", "1", "2", 8'h00},
		'{"F", "L", "A", "S", "H", "_", "V", 8'h00, 8'h00},
		'{"E", "E", "P", "R", "O", "M", "_", "V", 8'h00}
	};

	localparam logic [3:0] MARKER_LEN [NUM_MARKERS] = '{
		4'd9, 4'd9, 4'd6, 4'd5, 4'd7, 4'd8, 4'd7, 4'd8
	};

	// byte that marker k needs at a given age, age 0 being the newest byte
	function automatic logic [7:0] marker_want(input int k, input int age);
		int len;
		len = int'(MARKER_LEN[k]);
		if (age < len)
			return MARKER_TEXT[k][len - 1 - age];
		return 8'h00;
	endfunction

	function automatic logic marker_care(input int k, input int age);
		return age < int'(MARKER_LEN[k]);
	endfunction

	function automatic byte_row_t want_row(input int age);
		byte_row_t row;
		for (int k = 0; k < NUM_MARKERS; k++)
			row[k] = marker_want(k, age);
		return row;
	endfunction

	function automatic mask_t care_row(input int age);
		mask_t row;
		for (int k = 0; k < NUM_MARKERS; k++)
			row[k] = marker_care(k, age);
		return row;
	endfunction

	// lowest set bit wins
	function automatic logic [CODE_W-1:0] first_code(input mask_t seen);
		logic [CODE_W-1:0] code;
		code = MARKER_NONE;
		for (int k = NUM_MARKERS - 1; k >= 0; k--)
			if (seen[k])
				code = CODE_W'(k + 1);
		return code;
	endfunction

endpackage

/* rtl/smsu_if.sv */
interface smsu_in_if;
	import smsu_pkg::*;

	logic       valid;
	logic       ready;
	logic       start_scan;
	logic [7:0] byte_value;
	logic       rd_fail;

	modport source (output valid, start_scan, byte_value, rd_fail, input ready);
	modport sink   (input valid, start_scan, byte_value, rd_fail, output ready);
endinterface

interface smsu_out_if;
	import smsu_pkg::*;

	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] marker_code;

	modport source (output valid, marker_code, input ready);
	modport sink   (input valid, marker_code, output ready);
endinterface

/* rtl/smsu_cell.sv */
module smsu_cell (
	input  logic                clk,
	input  logic                shift_en,
	input  logic [7:0]          byte_in,
	input  smsu_pkg::byte_row_t want_bytes,
	input  smsu_pkg::mask_t     care,
	output logic [7:0]          byte_out,
	output smsu_pkg::mask_t     hit
);
	import smsu_pkg::*;

	logic [7:0] byte_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= byte_in;
		end
	end

	assign byte_out = byte_q;

	// a marker no longer than this age does not look at the cell
	always_comb begin
		for (int k = 0; k < NUM_MARKERS; k++)
			hit[k] = !care[k] || (byte_q == want_bytes[k]);
	end
endmodule

/* rtl/smsu_match.sv */
module smsu_match (
	input  smsu_pkg::mask_t          age_hit [0:smsu_pkg::HIST_DEPTH],
	input  logic [smsu_pkg::LEN_W-1:0] taken,
	output smsu_pkg::mask_t          new_hits
);
	import smsu_pkg::*;

	logic long_enough;

	assign long_enough = |taken[LEN_W-1:4];

	always_comb begin
		logic all_hit;
		for (int k = 0; k < NUM_MARKERS; k++) begin
			all_hit = 1'b1;
			for (int a = 0; a <= HIST_DEPTH; a++)
				all_hit = all_hit & age_hit[a][k];
			// the marker must fit in the bytes taken so far and this one
			new_hits[k] = all_hit &&
				(long_enough || (taken[3:0] >= (MARKER_LEN[k] - 4'd1)));
		end
	end
endmodule

/* rtl/save_marker_scanner_unit.sv */
// Save-type marker scanner. Bytes of a span enter on byte_in, one item per
// clock while byte_in is ready, and are shifted through a row of eight
// history cells; every marker is compared against the newest byte and the
// cells in the same cycle. A result (marker_code, 0 for none) sits in the
// output register from the cycle after the byte that ended the scan, and
// byte_in stalls only while that register holds an item that result has not
// taken. A scan starts with start_scan, reports at the first chunk end where
// a marker was seen, at the end of scan_length bytes, or on rd_fail, then
// goes idle. scan_length sits at byte address 0.
module save_marker_scanner_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	smsu_in_if.sink                         byte_in,
	smsu_out_if.source                      result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [smsu_pkg::ADDR_W-1:0]     paddr,
	input  logic [smsu_pkg::DATA_W-1:0]     pwdata,
	output logic [smsu_pkg::DATA_W-1:0]     prdata,
	output logic                            pready
);
	import smsu_pkg::*;

	logic [LEN_W-1:0]   scan_length_q;
	logic               active_q;
	logic [LEN_W-1:0]   taken_q;
	mask_t              seen_q;
	logic [CHUNK_W-1:0] chunk_q;
	logic               out_valid_q;
	logic [CODE_W-1:0]  out_code_q;

	logic               take, start, live, step, cfg_wr;
	logic [LEN_W-1:0]   taken_eff, taken_next;
	mask_t              seen_eff, seen_next, new_hits, head_hit;
	logic [CHUNK_W-1:0] chunk_eff, chunk_next;
	logic               span_done, chunk_end;

	logic [7:0] hist [0:HIST_DEPTH];
	mask_t      age_hit [0:HIST_DEPTH];

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SCAN_LENGTH);
	assign prdata = (paddr[2] == REG_SCAN_LENGTH) ?
		{{(DATA_W - LEN_W){1'b0}}, scan_length_q} : '0;

	assign byte_in.ready = !out_valid_q || result.ready;
	assign take  = byte_in.valid && byte_in.ready;
	assign start = byte_in.start_scan;
	assign live  = start || active_q;
	assign step  = take && live && !byte_in.rd_fail;

	assign taken_eff = start ? '0 : taken_q;
	assign seen_eff  = start ? '0 : seen_q;
	assign chunk_eff = start ? '0 : chunk_q;

	// age 0 is the incoming byte
	assign hist[0] = byte_in.byte_value;
	always_comb begin
		for (int k = 0; k < NUM_MARKERS; k++)
			head_hit[k] = (byte_in.byte_value == marker_want(k, 0));
	end
	assign age_hit[0] = head_hit;

	for (genvar a = 1; a <= HIST_DEPTH; a++) begin : g_cell
		logic [7:0] cell_in;
		// a new scan loads zeros behind the first byte
		if (a == 1) begin : g_head
			assign cell_in = hist[0];
		end else begin : g_body
			assign cell_in = start ? 8'h00 : hist[a-1];
		end
		smsu_cell u_cell (
			.clk        (clk),
			.shift_en   (step),
			.byte_in    (cell_in),
			.want_bytes (want_row(a)),
			.care       (care_row(a)),
			.byte_out   (hist[a]),
			.hit        (age_hit[a])
		);
	end

	smsu_match u_match (
		.age_hit  (age_hit),
		.taken    (taken_eff),
		.new_hits (new_hits)
	);

	assign seen_next  = seen_eff | new_hits;
	assign taken_next = taken_eff + LEN_W'(1);
	assign chunk_next = chunk_eff + CHUNK_W'(1);
	assign span_done  = taken_next >= scan_length_q;
	assign chunk_end  = (chunk_next >= CHUNK_W'(CHUNK_BYTES)) || span_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_length_q <= SCAN_LENGTH_RESET;
			active_q      <= 1'b0;
			taken_q       <= '0;
			seen_q        <= '0;
			chunk_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr) begin
				scan_length_q <= pwdata[LEN_W-1:0];
			end
			if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (take && live) begin
				if (byte_in.rd_fail) begin
					active_q    <= 1'b0;
					out_valid_q <= 1'b1;
				end else begin
					active_q <= 1'b1;
					taken_q  <= taken_next;
					if (chunk_end) begin
						chunk_q <= '0;
						seen_q  <= '0;
						if (seen_next != '0 || span_done) begin
							active_q    <= 1'b0;
							out_valid_q <= 1'b1;
						end
					end else begin
						chunk_q <= chunk_next;
						seen_q  <= seen_next;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && live) begin
			if (byte_in.rd_fail) begin
				out_code_q <= MARKER_NONE;
			end else if (chunk_end) begin
				out_code_q <= first_code(seen_next);
			end
		end
	end

	assign result.valid       = out_valid_q;
	assign result.marker_code = out_code_q;

	a_report_ends_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> !active_q)
		else $error("result raised while scan still active");

	a_chunk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		chunk_q < CHUNK_W'(CHUNK_BYTES))
		else $error("chunk offset reached chunk size");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_in.ready |-> out_valid_q)
		else $error("byte input stalled with empty output register");

	a_code_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_code_q <= MARKER_LAST))
		else $error("marker code out of range");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!active_q && !(take && start)) |=> !active_q)
		else $error("scan became active without start");
endmodule

/* test/save_marker_scanner_unit_tb.sv */
`timescale 1ns / 100ps

module save_marker_scanner_unit_tb;
	import smsu_pkg::*;

	localparam int          CLK_HALF      = 5;
	localparam int          RESET_CYCLES  = 9;
	localparam int          CYCLE_LIMIT   = 200000;
	localparam int          SETTLE_CYCLES = 6;
	localparam int          HOLD_CYCLES   = 300;
	localparam int          RANDOM_ITEMS  = 1150;
	localparam int          PHASE_ITEMS   = 120;
	localparam int          SPARE_REG     = 1;
	localparam logic [ADDR_W-1:0] SCAN_LEN_ADDR = ADDR_W'(4 * int'(REG_SCAN_LENGTH));
	localparam logic [ADDR_W-1:0] SPARE_ADDR    = ADDR_W'(4 * SPARE_REG);
	localparam logic [31:0] LEN_MASK      = 32'h03FF_FFFF;

	typedef enum logic [CODE_W-1:0] {
		NO_MARKER = 4'd0,
		SRAM_111,
		SRAM_112,
		SRAM_V,
		SRAM_NUL,
		FLASH1M,
		FLASH512,
		FLASH_V,
		EEPROM_ID
	} marker_e;

	typedef struct {
		logic       start_scan;
		logic [7:0] byte_value;
		logic       rd_fail;
		int         gap;
	} stream_item_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	smsu_in_if  byte_bus ();
	smsu_out_if result_bus ();

	save_marker_scanner_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_bus),
		.result  (result_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// stimulus and expectations
	stream_item_t byte_stream [$];
	marker_e      codes_due [$];
	logic [7:0]   scan_body [$];

	// scanner state as predicted
	logic [LEN_W-1:0] span_len;
	logic [63:0]      scan_hist;
	logic [7:0]       scan_seen;
	int               chunk_pos;
	logic [LEN_W-1:0] scan_taken;
	bit               scan_live;

	bit  tx_quiet;
	bit  rx_quiet;
	int  holds_asked;
	int  holds_served;
	int  hold_left;
	int  stall_left;
	int  gap_count;
	bit  in_fire;
	bit  out_fire;
	int  cycle_count;
	int  mismatches;
	int  items_taken;
	int  items_ignored;
	int  results_checked;
	int  scan_items_queued;
	stream_item_t next_item;

	always #(CLK_HALF) clk = ~clk;

	function automatic logic [71:0] signature(input marker_e m);
		case (m)
			SRAM_111:  return {"SRAM_V", "111"};
			SRAM_112:  return {"SRAM_V", "112"};
			SRAM_V:    return "SRAM_V";
			SRAM_NUL:  return {"SRAM", 8'h00};
			FLASH1M:   return "FLASH1M";
			FLASH512:  return "FLASH512";
			FLASH_V:   return "FLASH_V";
			EEPROM_ID: return {"EEPROM", "_V"};
			default:   return '0;
		endcase
	endfunction

	function automatic int signature_len(input marker_e m);
		case (m)
			SRAM_111, SRAM_112:  return 9;
			SRAM_V:              return 6;
			SRAM_NUL:            return 5;
			FLASH1M, FLASH_V:    return 7;
			FLASH512, EEPROM_ID: return 8;
			default:             return 0;
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $time, what);
		mismatches++;
	endtask

	task automatic write_span_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		if (addr == SCAN_LEN_ADDR)
			span_len = data[LEN_W-1:0];
	endtask

	// one accepted item through the predicted scanner
	task automatic scan_step(input stream_item_t it);
		logic [71:0] win;
		int          len;
		marker_e     winner;
		bit          span_done;
		if (it.start_scan) begin
			scan_hist  = '0;
			scan_seen  = '0;
			chunk_pos  = 0;
			scan_taken = '0;
			scan_live  = 1'b1;
		end
		if (!scan_live) begin
			items_ignored++;
			return;
		end
		if (it.rd_fail) begin
			scan_live = 1'b0;
			codes_due.insert(codes_due.size(), NO_MARKER);
			return;
		end
		win = {scan_hist, it.byte_value};
		for (int c = int'(SRAM_111); c <= int'(EEPROM_ID); c++) begin
			len = signature_len(marker_e'(c));
			if (int'(scan_taken) + 1 >= len &&
			    ((win ^ signature(marker_e'(c))) & ({72{1'b1}} >> (72 - 8 * len))) == '0)
				scan_seen[c - 1] = 1'b1;
		end
		scan_hist  = win[63:0];
		scan_taken = scan_taken + 1'b1;
		chunk_pos++;
		span_done = scan_taken >= span_len;
		if (chunk_pos >= CHUNK_BYTES || span_done) begin
			if (scan_seen != '0) begin
				winner = NO_MARKER;
				for (int c = int'(EEPROM_ID); c >= int'(SRAM_111); c--)
					if (scan_seen[c - 1])
						winner = marker_e'(c);
				scan_live = 1'b0;
				codes_due.insert(codes_due.size(), winner);
			end else if (span_done) begin
				scan_live = 1'b0;
				codes_due.insert(codes_due.size(), NO_MARKER);
			end else begin
				chunk_pos = 0;
				scan_seen = '0;
			end
		end
	endtask

	// acceptance on both channels and checking
	always @(posedge clk) begin
		in_fire  <= arst_n && byte_bus.valid && byte_bus.ready;
		out_fire <= arst_n && result_bus.valid && result_bus.ready;
		if (arst_n && byte_bus.valid && byte_bus.ready) begin
			items_taken++;
			scan_step('{byte_bus.start_scan, byte_bus.byte_value, byte_bus.rd_fail, 0});
		end
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (codes_due.size() == 0)
				report_mismatch($sformatf("marker_code %0d with no result expected",
					result_bus.marker_code));
			else begin
				if (result_bus.marker_code !== codes_due[0])
					report_mismatch($sformatf("marker_code %0d, expected %0d",
						result_bus.marker_code, codes_due[0]));
				void'(codes_due.pop_front());
				results_checked++;
			end
		end
	end

	// byte driver
	always @(negedge clk) begin
		if (!arst_n) begin
			byte_bus.valid <= 1'b0;
			gap_count <= 0;
		end else if (!byte_bus.valid || in_fire) begin
			if (byte_stream.size() == 0)
				byte_bus.valid <= 1'b0;
			else if (gap_count < byte_stream[0].gap) begin
				byte_bus.valid <= 1'b0;
				gap_count <= gap_count + 1;
			end else begin
				next_item = byte_stream.pop_front();
				byte_bus.valid       <= 1'b1;
				byte_bus.start_scan  <= next_item.start_scan;
				byte_bus.byte_value  <= next_item.byte_value;
				byte_bus.rd_fail     <= next_item.rd_fail;
				gap_count <= 0;
			end
		end
	end

	// result receiver: per-item stalls plus the occasional long hold
	always @(negedge clk) begin
		int draw;
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
		end else if (holds_served != holds_asked) begin
			holds_served <= holds_served + 1;
			hold_left <= HOLD_CYCLES;
			result_bus.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			result_bus.ready <= (hold_left == 1);
		end else if (out_fire) begin
			draw = rx_quiet ? 0 : $urandom_range(0, 9);
			stall_left <= draw;
			result_bus.ready <= (draw == 0);
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			result_bus.ready <= (stall_left == 1);
		end else
			result_bus.ready <= 1'b1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				codes_due.size());
			$display("Verification failed");
			$finish;
		end
	end

	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		write_span_reg(addr, data);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apb_read(input logic [ADDR_W-1:0] addr, output logic [DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		data = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_span_reg();
		logic [DATA_W-1:0] rd;
		apb_read(SCAN_LEN_ADDR, rd);
		if (rd !== DATA_W'(span_len))
			report_mismatch($sformatf("scan_length reads %0d, expected %0d", rd, span_len));
	endtask

	// wait until every expected result is out, then let the pipeline settle
	task automatic wait_idle();
		while (byte_stream.size() != 0 || byte_bus.valid || codes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_span_length(input logic [DATA_W-1:0] data);
		wait_idle();
		apb_write(SCAN_LEN_ADDR, data);
		check_span_reg();
	endtask

	task automatic push_item(input logic start, input logic [7:0] b, input logic fail);
		stream_item_t it;
		it.start_scan  = start;
		it.byte_value  = b;
		it.rd_fail     = fail;
		it.gap         = tx_quiet ? 0 : $urandom_range(0, 9);
		byte_stream.insert(byte_stream.size(), it);
	endtask

	// first keep characters of a marker, oldest first
	task automatic push_marker(input marker_e m, input int keep);
		logic [71:0] sig;
		int          len;
		sig = signature(m);
		len = signature_len(m);
		for (int i = len - 1; i >= len - keep; i--)
			scan_body.insert(scan_body.size(), sig[8 * i +: 8]);
	endtask

	function automatic logic [7:0] marker_char();
		marker_e     m;
		logic [71:0] sig;
		m   = marker_e'($urandom_range(int'(SRAM_111), int'(EEPROM_ID)));
		sig = signature(m);
		return sig[8 * $urandom_range(0, signature_len(m) - 1) +: 8];
	endfunction

	// first body byte opens the scan; fail_at < 0 means no read failure
	task automatic send_body(input int count, input int fail_at);
		for (int i = 0; i < count; i++)
			push_item(i == 0, scan_body[i], i == fail_at);
		scan_items_queued += count;
	endtask

	task automatic random_scan_items(input int len, output bit abandoned);
		int mode;
		int cut;
		random_scan_body(len);
		mode = $urandom_range(0, 99);
		abandoned = 1'b0;
		if (mode < 10) begin
			cut = $urandom_range(0, len - 1);
			send_body(cut + 1, cut);
		end else if (mode < 20 && len > 1) begin
			// restart before the span ends
			send_body($urandom_range(1, len - 1), -1);
			abandoned = 1'b1;
		end else
			send_body(len, -1);
	endtask

	task automatic random_scan_body(input int len);
		int      pick;
		marker_e m;
		scan_body.delete();
		while (scan_body.size() < len) begin
			pick = $urandom_range(0, 9);
			m = marker_e'($urandom_range(int'(SRAM_111), int'(EEPROM_ID)));
			if (pick < 3)
				push_marker(m, signature_len(m));
			else if (pick == 3)
				push_marker(m, $urandom_range(1, signature_len(m) - 1));
			else if (pick == 4)
				scan_body.insert(scan_body.size(), 8'($urandom));
			else
				scan_body.insert(scan_body.size(), marker_char());
		end
	endtask

	task automatic random_phase(input int len, input int target);
		int start_count;
		bit abandoned;
		start_count = scan_items_queued;
		abandoned = 1'b0;
		while (scan_items_queued - start_count < target || abandoned) begin
			random_scan_items(len, abandoned);
			// stray items while idle, dropped by the block
			if (!abandoned)
				repeat ($urandom_range(0, 2))
					push_item(1'b0, 8'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		int span_choices [12];
		int phase;
		int len;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		byte_bus.valid = 1'b0;
		byte_bus.start_scan = 1'b0;
		byte_bus.byte_value = '0;
		byte_bus.rd_fail = 1'b0;
		result_bus.ready = 1'b0;
		span_choices = '{1, 2, 3, 5, 6, 8, 9, 10, 16, 24, 40, 64};
		span_len = SCAN_LENGTH_RESET;
		scan_hist = '0;
		scan_seen = '0;
		chunk_pos = 0;
		scan_taken = '0;
		scan_live = 1'b0;
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		holds_asked = 0;
		holds_served = 0;
		cycle_count = 0;
		mismatches = 0;
		items_taken = 0;
		items_ignored = 0;
		results_checked = 0;
		scan_items_queued = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset value, idle item, length extremes, read failures, priorities
		check_span_reg();
		push_item(1'b0, 8'hFF, 1'b1);
		set_span_length(32'd0);
		scan_body.delete();
		scan_body.insert(0, 8'h00);
		send_body(1, -1);
		set_span_length(32'd1);
		push_item(1'b1, 8'hFF, 1'b1);
		push_item(1'b1, 8'hFF, 1'b0);
		set_span_length(32'd9);
		scan_body.delete();
		push_marker(SRAM_112, 9);
		send_body(9, -1);
		set_span_length(32'd5);
		scan_body.delete();
		push_marker(SRAM_NUL, 5);
		send_body(5, -1);
		set_span_length(32'd33554432);
		scan_body.delete();
		push_marker(FLASH1M, 7);
		scan_body.insert(scan_body.size(), 8'h00);
		// a marker already seen does not survive a read failure
		send_body(8, 7);
		wait_idle();
		apb_write(SPARE_ADDR, 32'h0000_0007);
		check_span_reg();

		// random scans over a spread of span lengths
		phase = 0;
		while (scan_items_queued < RANDOM_ITEMS) begin
			len = phase < 12 ? span_choices[phase] : $urandom_range(1, 80);
			set_span_length(($urandom() & ~LEN_MASK) | DATA_W'(len));
			tx_quiet = (phase % 4 == 3);
			rx_quiet = (phase % 4 == 3);
			random_phase(len, PHASE_ITEMS);
			tx_quiet = 1'b0;
			rx_quiet = 1'b0;
			phase++;
		end

		// receiver holds off while short scans pile up behind the output register
		set_span_length(32'd2);
		tx_quiet = 1'b1;
		holds_asked++;
		random_phase(2, 100);
		tx_quiet = 1'b0;
		wait_idle();

		if (codes_due.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", codes_due.size()));
		$display("%0d items accepted (%0d dropped while idle), %0d results checked",
			items_taken, items_ignored, results_checked);
		$display("spans of 0 to 80 bytes plus one of 33554432, restarts, read failures, %0d long hold",
			holds_served);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
